[rtl/rmq_pkg.sv]
// shared types and constants for the rotation matrix to quaternion pipeline
`timescale 1ns / 1ps
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int FIELD_W   = 16;
   localparam int MAG_W     = FIELD_W + 1;                  // |a - b| or |a + b|
   localparam int ARG_W     = FIELD_W + 1;                  // square root argument
   localparam int RAD_W     = 2 * ((ARG_W + FRAC_BITS + 1) / 2);
   localparam int ROOT_W    = RAD_W / 2;
   localparam int SREM_W    = ROOT_W + 4;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int DVD_W     = MAG_W + FRAC_BITS;
   localparam int Q_W       = MAG_W;
   localparam int DREM_W    = Q_W + 1;
   localparam int LANES     = 3;

   typedef enum logic [1:0] {
      SEL_W = 2'd0,
      SEL_X = 2'd1,
      SEL_Y = 2'd2,
      SEL_Z = 2'd3
   } sel_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] r00;
      logic signed [FIELD_W-1:0] r01;
      logic signed [FIELD_W-1:0] r02;
      logic signed [FIELD_W-1:0] r10;
      logic signed [FIELD_W-1:0] r11;
      logic signed [FIELD_W-1:0] r12;
      logic signed [FIELD_W-1:0] r20;
      logic signed [FIELD_W-1:0] r21;
      logic signed [FIELD_W-1:0] r22;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] quat_w;
      logic signed [FIELD_W-1:0] quat_x;
      logic signed [FIELD_W-1:0] quat_y;
      logic signed [FIELD_W-1:0] quat_z;
   } rsp_type;

   typedef struct packed {
      sel_type                          sel;
      logic [LANES-1:0]                 neg;
      logic [LANES-1:0][MAG_W-1:0]      mag;
      logic [RAD_W-1:0]                 rad;
      logic [SREM_W-1:0]                srem;
      logic [ROOT_W-1:0]                root;
      logic [ROOT_W-1:0]                quarter;
      logic [DEN_W-1:0]                 den;
      logic [LANES-1:0][DREM_W-1:0]     drem;
      logic [LANES-1:0][Q_W-1:0]        dq;
   } pipe_type;

endpackage

[rtl/rotation_matrix_to_quaternion.sv]
// rotation matrix to quaternion, pipelined square root and three dividers
// stages from req to rsp: decode, 16 root stages, rounding, 17 divide stages,
//   output register
// one matrix per cycle unless stalled; one root or quotient bit per stage
// each stage loads when it is empty or its successor moves, so bubbles close up
// reset clears all stage valid bits; payload registers are not reset
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   localparam int S_SQ  = 1;
   localparam int S_RND = S_SQ + ROOT_W;
   localparam int S_DV  = S_RND + 1;
   localparam int S_OUT = S_DV + Q_W;
   localparam int NSTG  = S_OUT + 1;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] en;
   pipe_type        pipe_ff [S_OUT];
   pipe_type        pipe_in [S_OUT];
   rsp_type         out_ff;
   rsp_type         out_in;

   // load enables ripple back from the output
   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NSTG-1];
   assign rsp_data  = out_ff;

   always_comb begin
      logic signed [FIELD_W+1:0] trace;
      logic signed [FIELD_W+2:0] arg;
      logic signed [MAG_W-1:0]   num [LANES];
      logic signed [MAG_W-1:0]   d1, d2, d3, p01, p02, p12;
      logic [SREM_W-1:0]         t_rem, t_trial;
      logic [DREM_W-1:0]         t_d;
      logic [ROOT_W-1:0]         r;
      logic [DVD_W-1:0]          dvd;
      logic [Q_W-1:0]            sv;
      logic [FIELD_W-1:0]        lane_v [LANES];
      logic [FIELD_W-1:0]        qv;
      pipe_type                  p;

      // decode: branch, root argument, numerators as sign and magnitude
      p     = '0;
      trace = (FIELD_W+2)'(req_data.r00) + (FIELD_W+2)'(req_data.r11)
            + (FIELD_W+2)'(req_data.r22);
      d1  = MAG_W'(req_data.r21) - MAG_W'(req_data.r12);
      d2  = MAG_W'(req_data.r02) - MAG_W'(req_data.r20);
      d3  = MAG_W'(req_data.r10) - MAG_W'(req_data.r01);
      p01 = MAG_W'(req_data.r01) + MAG_W'(req_data.r10);
      p02 = MAG_W'(req_data.r02) + MAG_W'(req_data.r20);
      p12 = MAG_W'(req_data.r12) + MAG_W'(req_data.r21);
      if (trace > 0) begin
         p.sel = SEL_W;
         arg = (FIELD_W+3)'(trace) + (FIELD_W+3)'(ONE);
         num[0] = d1; num[1] = d2; num[2] = d3;
      end else if (req_data.r00 > req_data.r11 && req_data.r00 > req_data.r22) begin
         p.sel = SEL_X;
         arg = (FIELD_W+3)'(ONE) + (FIELD_W+3)'(req_data.r00)
             - (FIELD_W+3)'(req_data.r11) - (FIELD_W+3)'(req_data.r22);
         num[0] = d1; num[1] = p01; num[2] = p02;
      end else if (req_data.r11 > req_data.r22) begin
         p.sel = SEL_Y;
         arg = (FIELD_W+3)'(ONE) + (FIELD_W+3)'(req_data.r11)
             - (FIELD_W+3)'(req_data.r00) - (FIELD_W+3)'(req_data.r22);
         num[0] = d2; num[1] = p01; num[2] = p12;
      end else begin
         p.sel = SEL_Z;
         arg = (FIELD_W+3)'(ONE) + (FIELD_W+3)'(req_data.r22)
             - (FIELD_W+3)'(req_data.r00) - (FIELD_W+3)'(req_data.r11);
         num[0] = d3; num[1] = p02; num[2] = p12;
      end
      for (int i = 0; i < LANES; i++) begin
         p.neg[i] = num[i][MAG_W-1];
         p.mag[i] = p.neg[i] ? (~num[i] + MAG_W'(1)) : num[i];
      end
      p.rad = arg[FIELD_W+2] ? '0
            : RAD_W'({arg[ARG_W-1:0], {FRAC_BITS{1'b0}}});
      pipe_in[0] = p;

      // square root, one result bit per stage
      for (int k = S_SQ; k < S_RND; k++) begin
         p       = pipe_ff[k-1];
         t_rem   = {p.srem[SREM_W-3:0], p.rad[RAD_W-1:RAD_W-2]};
         t_trial = {2'b00, p.root, 2'b01};
         if (t_rem >= t_trial) begin
            p.srem = t_rem - t_trial;
            p.root = {p.root[ROOT_W-2:0], 1'b1};
         end else begin
            p.srem = t_rem;
            p.root = {p.root[ROOT_W-2:0], 1'b0};
         end
         p.rad = {p.rad[RAD_W-3:0], 2'b00};
         pipe_in[k] = p;
      end

      // round the root to nearest, set up scale and dividends
      p = pipe_ff[S_RND-1];
      r = p.root + ROOT_W'(p.srem > SREM_W'(p.root));
      p.quarter = ROOT_W'(((ROOT_W+1)'(r) + (ROOT_W+1)'(1)) >> 1);
      p.den     = {r, 1'b0};
      for (int i = 0; i < LANES; i++) begin
         dvd       = {p.mag[i], {FRAC_BITS{1'b0}}} + DVD_W'(r);
         p.drem[i] = DREM_W'(dvd[DVD_W-1:Q_W]);
         p.dq[i]   = dvd[Q_W-1:0];
      end
      pipe_in[S_RND] = p;

      // restoring division, one quotient bit per stage in each lane
      for (int k = S_DV; k < S_OUT; k++) begin
         p = pipe_ff[k-1];
         for (int i = 0; i < LANES; i++) begin
            t_d = {p.drem[i][DREM_W-2:0], p.dq[i][Q_W-1]};
            if (t_d >= DREM_W'(p.den)) begin
               p.drem[i] = t_d - DREM_W'(p.den);
               p.dq[i]   = {p.dq[i][Q_W-2:0], 1'b1};
            end else begin
               p.drem[i] = t_d;
               p.dq[i]   = {p.dq[i][Q_W-2:0], 1'b0};
            end
         end
         pipe_in[k] = p;
      end

      // saturate, restore signs, place the picked component
      p = pipe_ff[S_OUT-1];
      for (int i = 0; i < LANES; i++) begin
         sv        = (p.dq[i] > Q_W'(ONE)) ? Q_W'(ONE) : p.dq[i];
         lane_v[i] = p.neg[i] ? (FIELD_W'(0) - FIELD_W'(sv)) : FIELD_W'(sv);
      end
      qv = (p.quarter > ROOT_W'(ONE)) ? FIELD_W'(ONE) : FIELD_W'(p.quarter);
      case (p.sel)
         SEL_W: begin
            out_in = {qv, lane_v[0], lane_v[1], lane_v[2]};
         end
         SEL_X: begin
            out_in = {lane_v[0], qv, lane_v[1], lane_v[2]};
         end
         SEL_Y: begin
            out_in = {lane_v[0], lane_v[1], qv, lane_v[2]};
         end
         SEL_Z: begin
            out_in = {lane_v[0], lane_v[1], lane_v[2], qv};
         end
         default: begin
            out_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < S_OUT; k++) begin
         if (en[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (en[NSTG-1]) begin
         out_ff <= out_in;
      end
   end

endmodule

[rtl/rmq_checker.sv]
// port checker for the rotation matrix to quaternion block, with its bind
`timescale 1ns / 1ps
module rmq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rmq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // a waiting request is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req changed while waiting");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // an empty or draining output never blocks the input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req blocked while output can move");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.quat_w >= -ONE && rsp_data.quat_w <= ONE &&
         rsp_data.quat_x >= -ONE && rsp_data.quat_x <= ONE &&
         rsp_data.quat_y >= -ONE && rsp_data.quat_y <= ONE &&
         rsp_data.quat_z >= -ONE && rsp_data.quat_z <= ONE)
      else $error("quaternion component out of range");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/rotation_matrix_to_quaternion_test.sv]
// testbench for the rotation matrix to quaternion pipeline
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_test;
   import rmq_pkg::*;

   localparam int LATENCY = 36;
   localparam int STALL_LIMIT = 4000;
   localparam int N_DIRECTED = 12;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type quat_queue[$];
   int      errors = 0;
   int      sent = 0;
   int      received = 0;
   int      idle_cycles = 0;
   int      send_idle = 0;
   int      recv_stall = 0;
   bit      timed_out = 1'b0;

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic longint round_sqrt(longint v);
      longint root;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         if ((root + (64'sd1 << b)) * (root + (64'sd1 << b)) <= v) begin
            root = root + (64'sd1 << b);
         end
      end
      if (v - root * root > root) begin
         root = root + 1;
      end
      return root;
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      if (den <= 0) begin
         return 0;
      end
      mag = (num < 0) ? -num : num;
      q = ((mag <<< FRAC_BITS) + (den >>> 1)) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic signed [15:0] clamp_one(longint x);
      if (x > ONE) begin
         return 16'(ONE);
      end
      if (x < -ONE) begin
         return 16'(-ONE);
      end
      return 16'(x);
   endfunction

   function automatic rsp_type matrix_to_quat(req_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint tr, arg, root, s, quarter, w, x, y, z;
      sel_type sel;
      rsp_type q;
      a00 = m.r00; a01 = m.r01; a02 = m.r02;
      a10 = m.r10; a11 = m.r11; a12 = m.r12;
      a20 = m.r20; a21 = m.r21; a22 = m.r22;
      tr = a00 + a11 + a22;
      if (tr > 0) begin
         sel = SEL_W;
         arg = tr + ONE;
      end else if (a00 > a11 && a00 > a22) begin
         sel = SEL_X;
         arg = ONE + a00 - a11 - a22;
      end else if (a11 > a22) begin
         sel = SEL_Y;
         arg = ONE + a11 - a00 - a22;
      end else begin
         sel = SEL_Z;
         arg = ONE + a22 - a00 - a11;
      end
      if (arg < 0) begin
         arg = 0;
      end
      root = round_sqrt(arg <<< FRAC_BITS);
      s = 2 * root;
      quarter = (root + 1) >>> 1;
      case (sel)
         SEL_W: begin
            w = quarter; x = round_div(a21 - a12, s);
            y = round_div(a02 - a20, s); z = round_div(a10 - a01, s);
         end
         SEL_X: begin
            w = round_div(a21 - a12, s); x = quarter;
            y = round_div(a01 + a10, s); z = round_div(a02 + a20, s);
         end
         SEL_Y: begin
            w = round_div(a02 - a20, s); x = round_div(a01 + a10, s);
            y = quarter; z = round_div(a12 + a21, s);
         end
         default: begin
            w = round_div(a10 - a01, s); x = round_div(a02 + a20, s);
            y = round_div(a12 + a21, s); z = quarter;
         end
      endcase
      q.quat_w = clamp_one(w);
      q.quat_x = clamp_one(x);
      q.quat_y = clamp_one(y);
      q.quat_z = clamp_one(z);
      return q;
   endfunction

   function automatic req_type make_matrix(int a00, int a01, int a02, int a10, int a11,
                                           int a12, int a20, int a21, int a22);
      req_type m;
      m.r00 = 16'(a00); m.r01 = 16'(a01); m.r02 = 16'(a02);
      m.r10 = 16'(a10); m.r11 = 16'(a11); m.r12 = 16'(a12);
      m.r20 = 16'(a20); m.r21 = 16'(a21); m.r22 = 16'(a22);
      return m;
   endfunction

   // directed rows; known marks a hand-typed expectation
   req_type directed_in[N_DIRECTED];
   rsp_type directed_out[N_DIRECTED];
   bit      directed_known[N_DIRECTED];

   initial begin
      // identity: w = 1
      directed_in[0] = make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
      directed_out[0] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      directed_known[0] = 1'b1;
      // 180 degrees about x, y and z
      directed_in[1] = make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
      directed_out[1] = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
      directed_known[1] = 1'b1;
      directed_in[2] = make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
      directed_out[2] = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0};
      directed_known[2] = 1'b1;
      directed_in[3] = make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
      directed_out[3] = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
      directed_known[3] = 1'b1;
      // all zero: trace not positive, ties fall through to z
      directed_in[4] = '0;
      directed_known[4] = 1'b0;
      // diagonal ties between x and y
      directed_in[5] = make_matrix(-100, 5, 7, 9, -100, 11, 13, 15, -200);
      directed_known[5] = 1'b0;
      // field extremes, saturation of quotients
      directed_in[6] = make_matrix(-32768, 32767, -32768, 32767, -32768, 32767,
                                   -32768, 32767, -32768);
      directed_known[6] = 1'b0;
      directed_in[7] = make_matrix(32767, -32768, 32767, -32768, 32767, -32768,
                                   32767, -32768, 32767);
      directed_known[7] = 1'b0;
      directed_in[8] = make_matrix(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0);
      directed_known[8] = 1'b0;
      directed_in[9] = make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768);
      directed_known[9] = 1'b0;
      // trace exactly one: positive, smallest w argument
      directed_in[10] = make_matrix(1, 100, -200, 300, 0, -400, 500, 600, 0);
      directed_known[10] = 1'b0;
      // 90 degrees about z
      directed_in[11] = make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
      directed_known[11] = 1'b0;
   end

   // random rotation-like matrix or raw noise
   function automatic req_type random_matrix();
      req_type m;
      int d;
      if ($urandom_range(0, 3) == 0) begin
         m = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      end else begin
         d = $urandom_range(0, 3);
         m = make_matrix($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                         $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                         $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                         $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                         $urandom_range(0, 32768) - 16384);
         // bias diagonal to steer branches
         if (d == 1) m.r00 = 16'($urandom_range(8000, 16384));
         if (d == 2) m.r11 = 16'($urandom_range(8000, 16384));
         if (d == 3) m.r22 = 16'($urandom_range(8000, 16384));
      end
      return m;
   endfunction

   // valid drops only while the sender idles
   task automatic send_matrix(req_type m);
      while ($urandom_range(1, 100) <= send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= m;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      quat_queue = {quat_queue, matrix_to_quat(m)};
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (quat_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(1, 100) > recv_stall);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (quat_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type want;
            want = quat_queue.pop_front();
            if (rsp_data.quat_w !== want.quat_w) begin
               $display("%0t: quat_w expected %0d actual %0d", $time, want.quat_w, rsp_data.quat_w);
               errors++;
            end
            if (rsp_data.quat_x !== want.quat_x) begin
               $display("%0t: quat_x expected %0d actual %0d", $time, want.quat_x, rsp_data.quat_x);
               errors++;
            end
            if (rsp_data.quat_y !== want.quat_y) begin
               $display("%0t: quat_y expected %0d actual %0d", $time, want.quat_y, rsp_data.quat_y);
               errors++;
            end
            if (rsp_data.quat_z !== want.quat_z) begin
               $display("%0t: quat_z expected %0d actual %0d", $time, want.quat_z, rsp_data.quat_z);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
         end
      end
   end

   initial begin
      int send_idle_set[4];
      int recv_stall_set[4];
      send_idle_set = '{0, 65, 0, 22};
      recv_stall_set = '{0, 0, 65, 22};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_known[i] && matrix_to_quat(directed_in[i]) !== directed_out[i]) begin
            $display("%0t: directed row %0d expected %h actual %h", $time, i,
                     directed_out[i], matrix_to_quat(directed_in[i]));
            errors++;
         end
         send_matrix(directed_in[i]);
      end
      for (int p = 0; p < 4; p++) begin
         send_idle = send_idle_set[p];
         recv_stall = recv_stall_set[p];
         for (int i = 0; i < 110; i++) begin
            send_matrix(random_matrix());
         end
         // hold off until the pipeline empties
         if (p == 1) begin
            drain_results();
         end
      end
      recv_stall = 0;
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d matrices (%0d results): all four branches, field extremes,",
               sent, received);
      $display("random sender gaps and receiver stalls");
      if (errors == 0) begin
         $display("rotation_matrix_to_quaternion_test: PASS");
      end else begin
         $display("rotation_matrix_to_quaternion_test: FAIL");
      end
      $finish;
   end

   initial begin
      wait (timed_out);
      $display("timeout after %0d idle cycles", STALL_LIMIT);
      $display("rotation_matrix_to_quaternion_test: FAIL");
      $finish;
   end

endmodule
